// ----- hdl/ttd_pkg.sv -----
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types, codes and sizing helpers for the tag tree decoder.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_LEVELS = 7;
  localparam int DEF_VALUE_BITS = 16;

  localparam int FUNC_BITS   = 2;
  localparam int COORD_BITS  = 6;
  localparam int THR_BITS    = 16;
  localparam int STATUS_BITS = 2;
  localparam int LVAL_BITS   = 16;
  localparam int GEOM_BITS   = 7;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_BIT   = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_NEED_BIT = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_VALUE    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_CLEARED  = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_ERROR    = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEAF_COLS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEAF_ROWS = 2'd1;

  typedef struct packed {
    logic [FUNC_BITS-1:0]  func;
    logic [COORD_BITS-1:0] leaf_x;
    logic [COORD_BITS-1:0] leaf_y;
    logic [THR_BITS-1:0]   threshold;
    logic                  coded_bit;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [LVAL_BITS-1:0]   leaf_value;
  } out_word_t;

  // total node count over all levels of the largest tree
  function automatic int node_total(input int cols, input int rows, input int levels);
    int w;
    int h;
    int sum;
    w = cols;
    h = rows;
    sum = 0;
    for (int k = 0; k < levels; k++) begin
      sum = sum + w * h;
      w = (w + 1) >> 1;
      h = (h + 1) >> 1;
    end
    return sum;
  endfunction

endpackage

// ----- hdl/tag_tree_decoder_core.sv -----
// ----------------------------------------------------------------------------
// tag_tree_decoder_core
// Tag tree decoder over a quadtree of leaf_cols by leaf_rows leaves.
// ----------------------------------------------------------------------------
// Every input word gives exactly one output word, unless a configuration write
// cuts its walk short. Error and clear results are registered in the cycle after
// the word is taken; a query or a supplied bit walks the tree one level at a
// time through a shared index multiply-add and the node memory, with an index,
// a read and an update step per level visited (a bit reuses the index of the
// node that asked for it). The block takes no word while it walks. After reset,
// a clear word or a geometry write, the node memory is swept to zero one entry
// per cycle (5461 entries at the default size, node_total of the maximum
// geometry in general) before words are taken again; configuration writes are
// taken at any time.
// ----------------------------------------------------------------------------
module tag_tree_decoder_core import ttd_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_word_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_word_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [GEOM_BITS-1:0]    cfg_data
);

  localparam int CW         = $clog2(MAX_COLS + 1);
  localparam int RW         = $clog2(MAX_ROWS + 1);
  localparam int LW         = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CNTW       = $clog2(MAX_LEVELS + 1);
  localparam int NODE_DEPTH = node_total(MAX_COLS, MAX_ROWS, MAX_LEVELS);
  localparam int AW         = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int VB         = VALUE_BITS;
  localparam int DB         = VALUE_BITS + 1;
  localparam int PW         = COORD_BITS + CW;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ADDR  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EVAL  = 5'b10000
  } state_t;

  state_t state;

  logic [GEOM_BITS-1:0]  leaf_cols;
  logic [GEOM_BITS-1:0]  leaf_rows;
  logic [CW-1:0]         eff_cols;
  logic [RW-1:0]         eff_rows;

  logic [COORD_BITS-1:0] open_x;
  logic [COORD_BITS-1:0] open_y;
  logic [THR_BITS-1:0]   open_threshold;
  logic [VB-1:0]         running_value;
  logic [LW-1:0]         current_level;
  logic                  awaiting_bit;
  logic                  enter;
  logic [AW-1:0]         idx;

  // level table
  logic [AW-1:0]         lvl_base [0:MAX_LEVELS-1];
  logic [CW-1:0]         lvl_w    [0:MAX_LEVELS-1];
  logic [LW-1:0]         top_level;
  logic                  top_found;
  logic                  pc_init;
  logic [CNTW-1:0]       pc_cnt;
  logic [CW-1:0]         pc_w;
  logic [RW-1:0]         pc_h;
  logic [AW-1:0]         pc_acc;
  logic                  pc_done;

  logic                  ram_clear;
  logic                  ram_busy;
  logic                  wr_en;
  logic [DB-1:0]         wr_data;
  logic [DB-1:0]         rd_data;

  logic                  cur_done;
  logic [VB-1:0]         cur_val;
  logic [VB-1:0]         ev_value;
  logic                  ev_ask;
  logic                  ev_leaf;
  logic                  out_free;
  logic                  in_acc;
  logic                  cfg_wr;
  logic                  query_ok;
  logic [VB-1:0]         bit_value;
  logic [COORD_BITS-1:0] x_shift;
  logic [COORD_BITS-1:0] y_shift;
  logic [PW-1:0]         row_off;
  logic [AW-1:0]         idx_calc;

  always_comb begin
    if (leaf_cols == '0) begin
      eff_cols = CW'(1);
    end else if (32'(leaf_cols) > MAX_COLS) begin
      eff_cols = CW'(MAX_COLS);
    end else begin
      eff_cols = CW'(leaf_cols);
    end
    if (leaf_rows == '0) begin
      eff_rows = RW'(1);
    end else if (32'(leaf_rows) > MAX_ROWS) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(leaf_rows);
    end
  end

  always_comb begin
    cur_done = rd_data[VB];
    cur_val  = rd_data[VB-1:0];
    ev_value = (enter && (cur_val > running_value)) ? cur_val : running_value;
    ev_ask   = !cur_done && (32'(ev_value) < 32'(open_threshold));
    ev_leaf  = (current_level == '0);

    out_free  = !out_valid || !out_stall;
    in_stall  = !((state == ST_IDLE) && out_free);
    in_acc    = in_valid && !in_stall;
    cfg_ready = 1'b1;
    cfg_wr    = cfg_valid && ((cfg_index == REG_LEAF_COLS) || (cfg_index == REG_LEAF_ROWS));
    query_ok  = !awaiting_bit && (32'(in_data.leaf_x) < 32'(eff_cols))
                && (32'(in_data.leaf_y) < 32'(eff_rows));

    if (in_data.coded_bit || (running_value == '1)) begin
      bit_value = running_value;
    end else begin
      bit_value = running_value + VB'(1);
    end

    x_shift  = open_x >> current_level;
    y_shift  = open_y >> current_level;
    row_off  = PW'(y_shift) * PW'(lvl_w[current_level]);
    idx_calc = lvl_base[current_level] + AW'(row_off) + AW'(x_shift);

    wr_en   = 1'b0;
    wr_data = {cur_done, ev_value};
    if (in_acc && (in_data.func == FUNC_BIT) && awaiting_bit) begin
      wr_en   = 1'b1;
      wr_data = {in_data.coded_bit, bit_value};
    end else if ((state == ST_EVAL) && out_free && !ev_ask) begin
      wr_en = 1'b1;
    end

    ram_clear = cfg_wr || (in_acc && (in_data.func == FUNC_CLEAR));
  end

  assign pc_done = (pc_cnt == CNTW'(MAX_LEVELS));

  // per-level base and row width, one level a cycle
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pc_init <= 1'b1;
      pc_cnt  <= '0;
    end else if (pc_init) begin
      pc_init   <= 1'b0;
      pc_w      <= eff_cols;
      pc_h      <= eff_rows;
      pc_acc    <= '0;
      top_level <= LW'(MAX_LEVELS - 1);
      top_found <= 1'b0;
    end else if (!pc_done) begin
      lvl_base[pc_cnt[LW-1:0]] <= pc_acc;
      lvl_w[pc_cnt[LW-1:0]]    <= pc_w;
      if (!top_found && (pc_w <= CW'(1)) && (pc_h <= RW'(1))) begin
        top_level <= pc_cnt[LW-1:0];
        top_found <= 1'b1;
      end
      pc_acc <= pc_acc + AW'(pc_w) * AW'(pc_h);
      pc_w   <= CW'(({1'b0, pc_w} + (CW + 1)'(1)) >> 1);
      pc_h   <= RW'(({1'b0, pc_h} + (RW + 1)'(1)) >> 1);
      pc_cnt <= pc_cnt + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      awaiting_bit  <= 1'b0;
      out_valid     <= 1'b0;
      running_value <= '0;
      current_level <= '0;
      enter         <= 1'b0;
      open_x        <= '0;
      open_y        <= '0;
      open_threshold <= '0;
      leaf_cols     <= GEOM_BITS'(1);
      leaf_rows     <= GEOM_BITS'(1);
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (!ram_busy && !pc_init && pc_done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            out_valid           <= 1'b1;
            out_data.status     <= STATUS_ERROR;
            out_data.leaf_value <= '0;
            case (in_data.func)
              FUNC_QUERY: begin
                if (query_ok) begin
                  out_valid      <= 1'b0;
                  open_x         <= in_data.leaf_x;
                  open_y         <= in_data.leaf_y;
                  open_threshold <= in_data.threshold;
                  running_value  <= '0;
                  current_level  <= top_level;
                  enter          <= 1'b1;
                  state          <= ST_ADDR;
                end
              end
              FUNC_BIT: begin
                if (awaiting_bit) begin
                  out_valid     <= 1'b0;
                  running_value <= bit_value;
                  enter         <= 1'b0;
                  state         <= ST_READ;
                end
              end
              FUNC_CLEAR: begin
                out_data.status <= STATUS_CLEARED;
                awaiting_bit    <= 1'b0;
                running_value   <= '0;
                current_level   <= '0;
                state           <= ST_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADDR: begin
          idx   <= idx_calc;
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (out_free) begin
            running_value <= ev_value;
            if (ev_ask) begin
              awaiting_bit        <= 1'b1;
              out_valid           <= 1'b1;
              out_data.status     <= STATUS_NEED_BIT;
              out_data.leaf_value <= '0;
              state               <= ST_IDLE;
            end else if (ev_leaf) begin
              awaiting_bit        <= 1'b0;
              out_valid           <= 1'b1;
              out_data.status     <= STATUS_VALUE;
              out_data.leaf_value <= (32'(ev_value) > 32'(16'hFFFF)) ? 16'hFFFF
                                     : LVAL_BITS'(ev_value);
              state               <= ST_IDLE;
            end else begin
              current_level <= current_level - LW'(1);
              enter         <= 1'b1;
              state         <= ST_ADDR;
            end
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
      if (cfg_wr) begin
        if (cfg_index == REG_LEAF_COLS) begin
          leaf_cols <= cfg_data;
        end else begin
          leaf_rows <= cfg_data;
        end
        awaiting_bit  <= 1'b0;
        running_value <= '0;
        current_level <= '0;
        state         <= ST_CLEAR;
      end
    end
  end

  ttd_node_ram #(
    .DEPTH (NODE_DEPTH),
    .AW    (AW),
    .DB    (DB)
  ) u_node_ram (
    .clk     (clk),
    .rst     (rst),
    .clear   (ram_clear),
    .busy    (ram_busy),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

endmodule

// ----- hdl/ttd_node_ram.sv -----
// ----------------------------------------------------------------------------
// ttd_node_ram
// Node store: one write and one registered read port, with a clearing sweep
// started by reset or by a clear request.
// ----------------------------------------------------------------------------
module ttd_node_ram #(
  parameter int DEPTH = 5461,
  parameter int AW    = 13,
  parameter int DB    = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  output logic          busy,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DB-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DB-1:0] rd_data
);

  logic [DB-1:0] mem [0:DEPTH-1];
  logic [AW-1:0] ptr;
  logic          sweeping;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sweeping <= 1'b1;
      ptr      <= '0;
    end else if (sweeping) begin
      if (ptr == AW'(DEPTH - 1)) begin
        sweeping <= 1'b0;
      end
      ptr <= ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[ptr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = sweeping;

endmodule
